@@ rtl/msbm_pkg.sv @@
`timescale 1ns / 1ps

package msbm_pkg;

    // frame geometry
    localparam int REQUEST_BITS = 12;
    localparam int REPLY_BITS   = 24;
    localparam int HALF_BITS    = 2 * REQUEST_BITS;

    // word kinds on the input side
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // function codes
    localparam logic [3:0] FN_INFO = 4'd1;
    localparam logic [3:0] FN_DATA = 4'd2;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MESSAGE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_START_CODE     = 2'd1;
    localparam logic [1:0] CFG_REPLY_DELAY    = 2'd2;

    // configuration reset values
    localparam logic [15:0] MESSAGE_PERIOD_RST = 16'd10000;
    localparam logic [3:0]  START_CODE_RST     = 4'b0110;
    localparam logic [3:0]  REPLY_DELAY_RST    = 4'd1;

    // one result word
    typedef struct packed {
        logic        line_level;
        logic        busy_res;
        logic        rejected;
        logic        reply_done;
        logic [1:0]  status;
        logic [3:0]  sensor_errors;
        logic [11:0] sensor_data;
        logic [3:0]  sensor_type;
    } result_t;

endpackage

@@ rtl/msbm_core.sv @@
`timescale 1ns / 1ps

module msbm_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 step,
    input  logic                 kind,
    input  logic                 rx_bit,
    input  logic [3:0]           address,
    input  logic [3:0]           function_code,
    output msbm_pkg::result_t    result
);

    // configuration registers
    logic [15:0] message_period_reg;
    logic [3:0]  start_code_reg;
    logic [3:0]  reply_delay_reg;

    // bus state
    logic [15:0] period_count_reg, period_count_next;
    logic        send_permit_reg, send_permit_next;
    logic        clock_phase_reg, clock_phase_next;
    logic        request_pending_reg, request_pending_next;
    logic [3:0]  held_address_reg, held_address_next;
    logic [3:0]  held_function_reg, held_function_next;
    logic        sending_reg, sending_next;
    logic [11:0] tx_frame_reg, tx_frame_next;
    logic [4:0]  half_bit_index_reg, half_bit_index_next;
    logic [4:0]  reply_left_reg, reply_left_next;
    logic [3:0]  delay_left_reg, delay_left_next;
    logic [23:0] reply_shift_reg, reply_shift_next;
    logic        line_reg, line_next;

    logic [15:0] count_inc;
    logic [4:0]  half_inc;
    logic [3:0]  bit_slot;
    logic [3:0]  bit_pos;
    logic [3:0]  echo_addr;
    logic [3:0]  echo_func;
    logic        busy_now;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            message_period_reg <= msbm_pkg::MESSAGE_PERIOD_RST;
            start_code_reg     <= msbm_pkg::START_CODE_RST;
            reply_delay_reg    <= msbm_pkg::REPLY_DELAY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                msbm_pkg::CFG_MESSAGE_PERIOD: message_period_reg <= cfg_wdata;
                msbm_pkg::CFG_START_CODE:     start_code_reg     <= cfg_wdata[3:0];
                msbm_pkg::CFG_REPLY_DELAY:    reply_delay_reg    <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // one word worth of bus activity
    always_comb begin
        period_count_next    = period_count_reg;
        send_permit_next     = send_permit_reg;
        clock_phase_next     = clock_phase_reg;
        request_pending_next = request_pending_reg;
        held_address_next    = held_address_reg;
        held_function_next   = held_function_reg;
        sending_next         = sending_reg;
        tx_frame_next        = tx_frame_reg;
        half_bit_index_next  = half_bit_index_reg;
        reply_left_next      = reply_left_reg;
        delay_left_next      = delay_left_reg;
        reply_shift_next     = reply_shift_reg;
        line_next            = line_reg;

        result = '0;
        busy_now = request_pending_reg || sending_reg || (reply_left_reg != 5'd0);

        count_inc = period_count_reg + 16'd1;
        half_inc  = half_bit_index_reg + 5'd1;
        bit_slot  = half_bit_index_reg[4:1];
        if (bit_slot >= 4'(msbm_pkg::REQUEST_BITS)) begin
            bit_slot = bit_slot - 4'(msbm_pkg::REQUEST_BITS);
        end
        bit_pos   = 4'(msbm_pkg::REQUEST_BITS - 1) - bit_slot;
        echo_addr = 4'd0;
        echo_func = 4'd0;

        if (kind == msbm_pkg::KIND_REQUEST) begin
            // start request: latch it unless one is pending or a transfer is under way
            if (busy_now) begin
                result.rejected = 1'b1;
            end else begin
                held_address_next    = address;
                held_function_next   = function_code;
                request_pending_next = 1'b1;
            end
        end else begin
            // pacing counter
            if (count_inc == message_period_reg) begin
                period_count_next = 16'd0;
                send_permit_next  = 1'b1;
            end else begin
                period_count_next = count_inc;
            end

            // idle line clock
            clock_phase_next = ~clock_phase_reg;
            if (!sending_reg) begin
                line_next = ~clock_phase_reg;
            end

            // reply sampling
            if ((reply_left_reg != 5'd0) && (delay_left_reg == 4'd0)) begin
                reply_left_next  = reply_left_reg - 5'd1;
                reply_shift_next = {reply_shift_reg[22:0], rx_bit};
                if (reply_left_reg == 5'd1) begin
                    echo_addr = reply_shift_next[23:20];
                    echo_func = reply_shift_next[19:16];
                    result.reply_done = 1'b1;
                    if ((echo_addr != held_address_reg) ||
                        (echo_func != held_function_reg)) begin
                        result.status = msbm_pkg::STATUS_MISMATCH;
                    end else begin
                        result.sensor_errors = reply_shift_next[15:12];
                        if (echo_func == msbm_pkg::FN_INFO) begin
                            result.sensor_type = reply_shift_next[11:8];
                        end else if (echo_func == msbm_pkg::FN_DATA) begin
                            result.sensor_data = reply_shift_next[11:0];
                        end else begin
                            result.status = msbm_pkg::STATUS_UNKNOWN;
                        end
                    end
                end
            end
            if (delay_left_reg != 4'd0) begin
                delay_left_next = delay_left_reg - 4'd1;
            end

            // manchester half-bit, driven inverted
            if (sending_reg) begin
                line_next = ~(tx_frame_reg[bit_pos] ^ half_bit_index_reg[0]);
                if (half_inc >= 5'(msbm_pkg::HALF_BITS)) begin
                    half_bit_index_next = 5'd0;
                    sending_next        = 1'b0;
                    reply_left_next     = 5'(msbm_pkg::REPLY_BITS);
                    delay_left_next     = reply_delay_reg;
                end else begin
                    half_bit_index_next = half_inc;
                end
            end
        end

        // launch a pending request once permitted
        if (request_pending_next && send_permit_next && !sending_next &&
            (reply_left_next == 5'd0)) begin
            request_pending_next = 1'b0;
            send_permit_next     = 1'b0;
            tx_frame_next        = {start_code_reg, held_address_next, held_function_next};
            half_bit_index_next  = 5'd0;
            sending_next         = 1'b1;
        end

        result.line_level = line_next;
        result.busy_res   = request_pending_next || sending_next || (reply_left_next != 5'd0);
    end

    // state update on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg    <= '0;
            send_permit_reg     <= 1'b0;
            clock_phase_reg     <= 1'b0;
            request_pending_reg <= 1'b0;
            held_address_reg    <= '0;
            held_function_reg   <= '0;
            sending_reg         <= 1'b0;
            tx_frame_reg        <= '0;
            half_bit_index_reg  <= '0;
            reply_left_reg      <= '0;
            delay_left_reg      <= '0;
            reply_shift_reg     <= '0;
            line_reg            <= 1'b0;
        end else if (step) begin
            period_count_reg    <= period_count_next;
            send_permit_reg     <= send_permit_next;
            clock_phase_reg     <= clock_phase_next;
            request_pending_reg <= request_pending_next;
            held_address_reg    <= held_address_next;
            held_function_reg   <= held_function_next;
            sending_reg         <= sending_next;
            tx_frame_reg        <= tx_frame_next;
            half_bit_index_reg  <= half_bit_index_next;
            reply_left_reg      <= reply_left_next;
            delay_left_reg      <= delay_left_next;
            reply_shift_reg     <= reply_shift_next;
            line_reg            <= line_next;
        end
    end

endmodule

@@ rtl/msbm_out.sv @@
`timescale 1ns / 1ps

module msbm_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  msbm_pkg::result_t    in_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output msbm_pkg::result_t    out_result
);

    logic              valid_reg;
    msbm_pkg::result_t result_reg;

    // take a new word whenever the held one leaves or none is held
    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= in_result;
        end
    end

endmodule

@@ rtl/manchester_sensor_bus_master_top.sv @@
`timescale 1ns / 1ps

// Manchester sensor bus master. Each input word is either a timer tick
// (tuser = 0), carrying the sampled bus level, or a start request
// (tuser = 1) carrying a sensor address and function code. Every input
// word yields exactly one result word, registered, in the cycle after it is
// accepted; a new word is accepted every cycle as long as the result
// register is empty or being drained, so throughput is one word per clock.
// The request frame is start code, address, function, msb first, two
// inverted manchester half-bits per bit, one half-bit per tick; the reply is
// 24 bits sampled one per tick after the configured delay. Configuration is
// to be written only while the bus is idle, which the block does not enforce;
// after reset the registers hold period 10000, start code 6 and reply delay 1.
module manchester_sensor_bus_master_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_bit[0], address[4:1], function_code[8:5]
    input  logic        s_tuser,   // kind[0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // line_level[0], busy_res[1], rejected[2],
                                   // reply_done[3], status[5:4], sensor_errors[9:6],
                                   // sensor_data[21:10], sensor_type[25:22]
);

    msbm_pkg::result_t core_result;
    msbm_pkg::result_t out_result;
    logic              step;

    assign step = s_tvalid && s_tready;

    // bus state machine and reply decode
    msbm_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .step          (step),
        .kind          (s_tuser),
        .rx_bit        (s_tdata[0]),
        .address       (s_tdata[4:1]),
        .function_code (s_tdata[8:5]),
        .result        (core_result)
    );

    // result register
    msbm_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_result  (core_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // pack result fields
    assign m_tdata = {6'd0,
                      out_result.sensor_type,
                      out_result.sensor_data,
                      out_result.sensor_errors,
                      out_result.status,
                      out_result.reply_done,
                      out_result.rejected,
                      out_result.busy_res,
                      out_result.line_level};

endmodule

@@ sim/tb_manchester_sensor_bus_master_top.sv @@
`timescale 1ns / 1ps

module tb_manchester_sensor_bus_master_top;

    localparam int CYCLE_LIMIT = 600000;

    // one input word as the driver sends it
    typedef struct packed {
        logic       kind;
        logic       rx_bit;
        logic [3:0] address;
        logic [3:0] function_code;
    } bus_item_t;

    // one result word, laid out as on m_tdata
    typedef struct packed {
        logic [5:0]  pad;
        logic [3:0]  sensor_type;
        logic [11:0] sensor_data;
        logic [3:0]  sensor_errors;
        logic [1:0]  status;
        logic        reply_done;
        logic        rejected;
        logic        busy_res;
        logic        line_level;
    } bus_word_t;

    // registers plus internal state of the bus master
    typedef struct packed {
        logic [15:0] message_period;
        logic [3:0]  start_code;
        logic [3:0]  reply_delay;
        logic [15:0] period_count;
        logic        send_permit;
        logic        clock_phase;
        logic        request_pending;
        logic [3:0]  held_address;
        logic [3:0]  held_function;
        logic        sending;
        logic [11:0] tx_frame;
        logic [4:0]  half_bit_index;
        logic [4:0]  reply_left;
        logic [3:0]  delay_left;
        logic [23:0] reply_shift;
        logic        line_reg;
    } bus_state_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = msbm_pkg::CFG_MESSAGE_PERIOD;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;
    logic        s_tuser   = msbm_pkg::KIND_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    bus_item_t   pending_words[$];
    bus_word_t   expected_words[$];
    bus_state_t  line_model;     // follows accepted words
    bus_state_t  plan_model;     // follows queued words, used to time the reply bits
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycle_count   = 0;
    int          mismatches    = 0;
    int          words_checked = 0;
    int          replies_ok    = 0;
    int          replies_bad   = 0;
    int          replies_unk   = 0;
    int          rejects_seen  = 0;

    manchester_sensor_bus_master_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // rx_bit[0], address[4:1], function_code[8:5]
        .s_tuser   (s_tuser),   // kind[0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // line_level[0], busy_res[1], rejected[2], reply_done[3],
                                // status[5:4], sensor_errors[9:6], sensor_data[21:10],
                                // sensor_type[25:22]
    );

    always #6 aclk = ~aclk;

    function automatic bus_state_t reset_state();
        bus_state_t st;
        st = '0;
        st.message_period = msbm_pkg::MESSAGE_PERIOD_RST;
        st.start_code     = msbm_pkg::START_CODE_RST;
        st.reply_delay    = msbm_pkg::REPLY_DELAY_RST;
        return st;
    endfunction

    // advance the bus master by one word and return the result word
    function automatic bus_word_t bus_master_step(inout bus_state_t st, input logic kind,
                                                  input logic rx, input logic [3:0] addr,
                                                  input logic [3:0] fn);
        bus_word_t  w;
        logic [3:0] echo_addr;
        logic [3:0] echo_fn;
        logic       tx_bit;
        w = '0;
        if (kind == msbm_pkg::KIND_REQUEST) begin
            if (st.request_pending || st.sending || st.reply_left != 5'd0) begin
                w.rejected = 1'b1;
            end else begin
                st.held_address    = addr;
                st.held_function   = fn;
                st.request_pending = 1'b1;
            end
        end else begin
            // pacing counter grants a send permit
            st.period_count = st.period_count + 16'd1;
            if (st.period_count == st.message_period) begin
                st.period_count = 16'd0;
                st.send_permit  = 1'b1;
            end
            st.clock_phase = ~st.clock_phase;
            if (!st.sending) st.line_reg = st.clock_phase;

            // reply sampling, msb first
            if (st.reply_left != 5'd0 && st.delay_left == 4'd0) begin
                st.reply_left  = st.reply_left - 5'd1;
                st.reply_shift = {st.reply_shift[22:0], rx};
                if (st.reply_left == 5'd0) begin
                    echo_addr    = st.reply_shift[23:20];
                    echo_fn      = st.reply_shift[19:16];
                    w.reply_done = 1'b1;
                    if (echo_addr != st.held_address || echo_fn != st.held_function) begin
                        w.status = msbm_pkg::STATUS_MISMATCH;
                    end else begin
                        w.sensor_errors = st.reply_shift[15:12];
                        if (echo_fn == msbm_pkg::FN_INFO)
                            w.sensor_type = st.reply_shift[11:8];
                        else if (echo_fn == msbm_pkg::FN_DATA)
                            w.sensor_data = st.reply_shift[11:0];
                        else
                            w.status = msbm_pkg::STATUS_UNKNOWN;
                    end
                end
            end
            if (st.delay_left != 4'd0) st.delay_left = st.delay_left - 4'd1;

            // request frame, two inverted manchester half-bits per bit
            if (st.sending) begin
                tx_bit = st.tx_frame[msbm_pkg::REQUEST_BITS - 1 -
                                     int'(st.half_bit_index >> 1)];
                st.line_reg       = tx_bit ^ st.half_bit_index[0] ^ 1'b1;
                st.half_bit_index = st.half_bit_index + 5'd1;
                if (int'(st.half_bit_index) >= msbm_pkg::HALF_BITS) begin
                    st.half_bit_index = 5'd0;
                    st.sending        = 1'b0;
                    st.reply_left     = 5'(msbm_pkg::REPLY_BITS);
                    st.delay_left     = st.reply_delay;
                end
            end
        end

        // launch a pending request once permitted
        if (st.request_pending && st.send_permit && !st.sending && st.reply_left == 5'd0) begin
            st.request_pending = 1'b0;
            st.send_permit     = 1'b0;
            st.tx_frame        = {st.start_code, st.held_address, st.held_function};
            st.half_bit_index  = 5'd0;
            st.sending         = 1'b1;
        end
        w.line_level = st.line_reg;
        w.busy_res   = st.request_pending || st.sending || st.reply_left != 5'd0;
        return w;
    endfunction

    function automatic void push_word(input logic kind, input logic rx,
                                      input logic [3:0] addr, input logic [3:0] fn);
        bus_item_t item;
        item.kind          = kind;
        item.rx_bit        = rx;
        item.address       = addr;
        item.function_code = fn;
        pending_words.push_back(item);
        void'(bus_master_step(plan_model, kind, rx, addr, fn));
    endfunction

    // ticks, with stray requests when noisy, until the bus is free, feeding the reply bits when they are sampled
    function automatic void queue_reply_ticks(input logic [23:0] reply, input bit noisy);
        logic rx;
        while (plan_model.request_pending || plan_model.sending ||
               plan_model.reply_left != 5'd0) begin
            if (noisy && $urandom_range(15) == 0) begin
                push_word(msbm_pkg::KIND_REQUEST, 1'($urandom), 4'($urandom), 4'($urandom));
            end else begin
                if (plan_model.reply_left != 5'd0 && plan_model.delay_left == 4'd0)
                    rx = reply[plan_model.reply_left - 5'd1];
                else
                    rx = 1'($urandom);
                push_word(msbm_pkg::KIND_TICK, rx, 4'($urandom), 4'($urandom));
            end
        end
    endfunction

    function automatic void queue_exchange(input logic [3:0] addr, input logic [3:0] fn,
                                           input logic [23:0] reply, input bit noisy);
        push_word(msbm_pkg::KIND_REQUEST, 1'($urandom), addr, fn);
        queue_reply_ticks(reply, noisy);
    endfunction

    // random exchanges: mostly well-formed, some with broken echo or odd functions
    function automatic void random_traffic(input int n_words);
        logic [3:0]  addr;
        logic [3:0]  fn;
        logic [23:0] reply;
        int          pick;
        while (pending_words.size() < n_words) begin
            addr = 4'($urandom);
            pick = $urandom_range(99);
            fn   = (pick < 40) ? msbm_pkg::FN_DATA :
                   (pick < 80) ? msbm_pkg::FN_INFO : 4'($urandom);
            reply = {addr, fn, 16'($urandom)};
            if ($urandom_range(99) < 15) reply[23:16] = reply[23:16] ^ 8'($urandom_range(1, 255));
            queue_exchange(addr, fn, reply, 1'b1);
            repeat ($urandom_range(0, 4))
                push_word(msbm_pkg::KIND_TICK, 1'($urandom), 4'($urandom), 4'($urandom));
        end
    endfunction

    // all three registers, write enable held high across them
    task automatic write_config(input logic [15:0] period, input logic [3:0] code,
                                input logic [3:0] delay);
        cfg_wr_en <= 1'b1;
        cfg_index <= msbm_pkg::CFG_MESSAGE_PERIOD;
        cfg_wdata <= period;
        @(posedge aclk);
        cfg_index <= msbm_pkg::CFG_START_CODE;
        cfg_wdata <= {12'd0, code};
        @(posedge aclk);
        cfg_index <= msbm_pkg::CFG_REPLY_DELAY;
        cfg_wdata <= {12'd0, delay};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        line_model.message_period = period;
        line_model.start_code     = code;
        line_model.reply_delay    = delay;
        plan_model.message_period = period;
        plan_model.start_code     = code;
        plan_model.reply_delay    = delay;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_words.size() != 0);
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s at word %0d: expected %0h, got %0h",
                     field, words_checked, want_v, got_v);
    endtask

    // driver: next word goes out once the current one is taken
    always @(posedge aclk) begin
        bus_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_words.push_back(bus_master_step(line_model, s_tuser, s_tdata[0],
                                                         s_tdata[4:1], s_tdata[8:5]));
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= item.kind;
                    s_tdata  <= {7'd0, item.function_code, item.address, item.rx_bit};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge aclk) begin
        bus_word_t got;
        bus_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_words.size() == 0) begin
                    flag_mismatch("unexpected word", 32'd0, m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    if (got.line_level != want.line_level)
                        flag_mismatch("line_level", 32'(want.line_level),
                                      32'(got.line_level));
                    if (got.busy_res != want.busy_res)
                        flag_mismatch("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                    if (got.rejected != want.rejected)
                        flag_mismatch("rejected", 32'(want.rejected), 32'(got.rejected));
                    if (got.reply_done != want.reply_done)
                        flag_mismatch("reply_done", 32'(want.reply_done),
                                      32'(got.reply_done));
                    if (got.status != want.status)
                        flag_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.sensor_errors != want.sensor_errors)
                        flag_mismatch("sensor_errors", 32'(want.sensor_errors),
                                      32'(got.sensor_errors));
                    if (got.sensor_data != want.sensor_data)
                        flag_mismatch("sensor_data", 32'(want.sensor_data),
                                      32'(got.sensor_data));
                    if (got.sensor_type != want.sensor_type)
                        flag_mismatch("sensor_type", 32'(want.sensor_type),
                                      32'(got.sensor_type));
                    if (want.rejected) rejects_seen++;
                    if (want.reply_done) begin
                        if (want.status == msbm_pkg::STATUS_OK) replies_ok++;
                        else if (want.status == msbm_pkg::STATUS_MISMATCH) replies_bad++;
                        else replies_unk++;
                    end
                end
                words_checked++;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words checked", cycle_count, words_checked);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [3:0] code;
        logic [3:0] delay;
        logic [3:0] addr;
        logic [3:0] fn;
        line_model = reset_state();
        plan_model = reset_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender rarely idle, receiver mostly stalled
        send_idle_pct = 7;
        recv_idle_pct = 71;
        write_config(16'd1, 4'd15, 4'd0);
        // full-scale data reply, info reply, echo mismatch, unknown functions
        queue_exchange(4'd15, msbm_pkg::FN_DATA, {4'd15, msbm_pkg::FN_DATA, 16'hFFFF}, 1'b0);
        queue_exchange(4'd0, msbm_pkg::FN_INFO, {4'd0, msbm_pkg::FN_INFO, 16'hA5C3}, 1'b0);
        queue_exchange(4'd5, msbm_pkg::FN_DATA, {4'd6, msbm_pkg::FN_DATA, 16'h1234}, 1'b0);
        queue_exchange(4'd9, 4'd0, {4'd9, 4'd0, 16'hF123}, 1'b0);
        queue_exchange(4'd10, 4'd15, {4'd10, 4'd15, 16'h8421}, 1'b0);
        // second request while the first is on the bus
        push_word(msbm_pkg::KIND_REQUEST, 1'b1, 4'd3, msbm_pkg::FN_DATA);
        push_word(msbm_pkg::KIND_REQUEST, 1'b1, 4'd12, msbm_pkg::FN_INFO);
        queue_reply_ticks({4'd3, msbm_pkg::FN_DATA, 16'h0F0F}, 1'b0);
        wait_drained();

        write_config(16'd7, 4'd0, 4'd15);
        random_traffic(200);
        wait_drained();

        // sender mostly idle, receiver rarely stalled
        send_idle_pct = 71;
        recv_idle_pct = 7;
        write_config(16'($urandom_range(2, 40)), 4'($urandom), 4'($urandom));
        random_traffic(200);
        wait_drained();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(16'($urandom_range(2, 40)), 4'($urandom), 4'($urandom));
        random_traffic(150);
        wait_drained();

        // longest period, then lowered below the running count so no permit follows
        code  = 4'($urandom);
        delay = 4'($urandom);
        write_config(16'hFFFF, code, delay);
        repeat (100)
            push_word(msbm_pkg::KIND_TICK, 1'($urandom), 4'($urandom), 4'($urandom));
        if (plan_model.send_permit)
            queue_exchange(4'd1, msbm_pkg::FN_INFO,
                           {4'd1, msbm_pkg::FN_INFO, 16'($urandom)}, 1'b0);
        addr = 4'($urandom);
        fn   = msbm_pkg::FN_DATA;
        push_word(msbm_pkg::KIND_REQUEST, 1'b0, addr, fn);
        wait_drained();
        write_config(16'd50, code, delay);
        repeat (100)
            push_word(msbm_pkg::KIND_TICK, 1'($urandom), 4'($urandom), 4'($urandom));
        push_word(msbm_pkg::KIND_REQUEST, 1'b1, 4'($urandom), msbm_pkg::FN_INFO);
        wait_drained();

        repeat (8) @(posedge aclk);
        $display("checked %0d result words: %0d good replies, %0d echo mismatches, %0d unknown",
                 words_checked, replies_ok, replies_bad, replies_unk);
        $display("function replies, %0d rejected requests; periods 1 to 65535, one lowered %s",
                 rejects_seen, "below the running count");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                     expected_words.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/msbm_pkg.sv
rtl/msbm_core.sv
rtl/msbm_out.sv
rtl/manchester_sensor_bus_master_top.sv
sim/tb_manchester_sensor_bus_master_top.sv
